// ----- src/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam int unsigned TickWidth = 16;
  localparam int unsigned PhaseWidth = 5;
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  // register index, taken from paddr[2]
  localparam logic REG_PHASE_TICKS = 1'b0;

  localparam logic [TickWidth-1:0] PhaseTicksReset = 16'd1;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_RACK  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_TICK  = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] write_data;
    logic       ack_level;
    logic       sda_level;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       rejected;
  } res_t;

endpackage

// ----- src/i2cm_cfg.sv -----
module i2cm_cfg
  import i2cm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output logic [TickWidth-1:0]    phase_ticks
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PhaseTicksReset;
    end else if (wr_en && (reg_index == REG_PHASE_TICKS)) begin
      phase_ticks <= pwdata[TickWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_PHASE_TICKS) begin
      prdata = {{(ApbDataWidth-TickWidth){1'b0}}, phase_ticks};
    end
  end

endmodule

// ----- src/i2cm_seq.sv -----
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  req_t                 item,
  input  logic [TickWidth-1:0] phase_ticks,
  output res_t                 result
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_STOP  = 7'b0000100,
    ST_WRITE = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_RACK  = 7'b0100000,
    ST_SACK  = 7'b1000000
  } op_state_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  function automatic op_state_t cmd_to_state(cmd_t c);
    op_state_t s;
    case (c)
      CMD_START: s = ST_START;
      CMD_STOP:  s = ST_STOP;
      CMD_WRITE: s = ST_WRITE;
      CMD_READ:  s = ST_READ;
      CMD_RACK:  s = ST_RACK;
      CMD_SACK:  s = ST_SACK;
      default:   s = ST_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [PhaseWidth-1:0] phase_total(op_state_t s);
    logic [PhaseWidth-1:0] n;
    case (s)
      ST_STOP:           n = 5'd2;
      ST_WRITE, ST_READ: n = 5'd17;
      default:           n = 5'd3;
    endcase
    return n;
  endfunction

  // bit of the byte handled in odd phase p, msb first
  function automatic logic [2:0] bit_of_phase(logic [PhaseWidth-1:0] p);
    logic [PhaseWidth-1:0] pm1;
    pm1 = p - 5'd1;
    return 3'd7 - pm1[3:1];
  endfunction

  // line levels at the start of phase p
  function automatic lines_t enter_phase(op_state_t s, logic [PhaseWidth-1:0] p,
                                         logic [7:0] sb, logic ack, lines_t cur);
    lines_t l;
    l = cur;
    case (s)
      ST_START: begin
        if (p == 5'd0) begin
          l.sda = 1'b1;
          l.scl = 1'b1;
        end else if (p == 5'd1) begin
          l.sda = 1'b0;
        end else begin
          l.scl = 1'b0;
        end
      end
      ST_STOP: begin
        if (p == 5'd0) begin
          l.sda = 1'b0;
          l.scl = 1'b0;
        end else begin
          l.scl = 1'b1;
        end
      end
      ST_WRITE: begin
        if (p == 5'd0) begin
          l.scl = 1'b0;
        end else if (p[0]) begin
          l.sda = sb[bit_of_phase(p)];
          l.scl = 1'b1;
        end else begin
          l.scl = 1'b0;
        end
      end
      ST_READ, ST_RACK: begin
        if (p == 5'd0) begin
          l.sda = 1'b1;
          l.scl = 1'b0;
        end else begin
          l.scl = p[0];
        end
      end
      ST_SACK: begin
        if (p == 5'd1) begin
          l.sda = ack;
          l.scl = 1'b1;
        end else begin
          l.scl = 1'b0;
        end
      end
      default: begin
        l = cur;
      end
    endcase
    return l;
  endfunction

  op_state_t             op, op_next;
  logic [PhaseWidth-1:0] phase, phase_next;
  logic [TickWidth-1:0]  tick_count, tick_count_next;
  logic [7:0]            shift_byte, shift_byte_next;
  lines_t                lines, lines_next;
  logic                  ack_to_send, ack_to_send_next;
  logic                  ack_seen, ack_seen_next;
  logic [7:0]            last_read, last_read_next;

  logic                  busy;
  logic                  done;
  logic                  rej;
  logic [TickWidth-1:0]  len;
  logic [TickWidth-1:0]  tick_inc;
  logic [PhaseWidth-1:0] phase_inc;

  assign busy      = (op != ST_IDLE);
  assign len       = (phase_ticks == '0) ? {{(TickWidth-1){1'b0}}, 1'b1} : phase_ticks;
  assign tick_inc  = tick_count + {{(TickWidth-1){1'b0}}, 1'b1};
  assign phase_inc = phase + 5'd1;

  always_comb begin
    op_next          = op;
    phase_next       = phase;
    tick_count_next  = tick_count;
    shift_byte_next  = shift_byte;
    lines_next       = lines;
    ack_to_send_next = ack_to_send;
    ack_seen_next    = ack_seen;
    last_read_next   = last_read;
    done             = 1'b0;
    rej              = 1'b0;

    case (item.command)
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_RACK, CMD_SACK: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          op_next         = cmd_to_state(item.command);
          phase_next      = '0;
          tick_count_next = '0;
          if (item.command == CMD_WRITE) shift_byte_next = item.write_data;
          if (item.command == CMD_READ) shift_byte_next = 8'd0;
          if (item.command == CMD_SACK) ack_to_send_next = item.ack_level;
          lines_next = enter_phase(op_next, 5'd0, shift_byte_next, ack_to_send_next, lines);
        end
      end
      CMD_TICK: begin
        if (busy) begin
          if (tick_inc >= len) begin
            tick_count_next = '0;
            // sample sda at the end of an scl-high phase
            if (lines.scl && phase[0]) begin
              if (op == ST_READ) shift_byte_next[bit_of_phase(phase)] = item.sda_level;
              if (op == ST_RACK) ack_seen_next = item.sda_level;
            end
            if (phase_inc >= phase_total(op)) begin
              if (op == ST_STOP) lines_next.sda = 1'b1;
              if (op == ST_READ) last_read_next = shift_byte_next;
              op_next    = ST_IDLE;
              phase_next = '0;
              done       = 1'b1;
            end else begin
              phase_next = phase_inc;
              lines_next = enter_phase(op, phase_inc, shift_byte_next, ack_to_send, lines);
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      default: begin
        // unused command code, no effect
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op          <= ST_IDLE;
      phase       <= '0;
      tick_count  <= '0;
      shift_byte  <= 8'd0;
      lines       <= '{scl: 1'b1, sda: 1'b1};
      ack_to_send <= 1'b0;
      ack_seen    <= 1'b0;
      last_read   <= 8'd0;
    end else if (advance) begin
      op          <= op_next;
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      shift_byte  <= shift_byte_next;
      lines       <= lines_next;
      ack_to_send <= ack_to_send_next;
      ack_seen    <= ack_seen_next;
      last_read   <= last_read_next;
    end
  end

  always_comb begin
    result.scl_out      = lines_next.scl;
    result.sda_out      = lines_next.sda;
    result.busy_res     = (op_next != ST_IDLE);
    result.done_res     = done;
    result.read_data    = last_read_next;
    result.ack_received = ack_seen_next;
    result.rejected     = rej;
  end

endmodule

// ----- src/i2c_master_bit_engine_core.sv -----
// I2C master bit sequencer. Send start, stop, write byte, read byte, read ack or send ack
// requests while idle, then tick requests to step the SCL/SDA phases; each phase lasts
// phase_ticks ticks (register 0, zero counts as one). Every request returns one result
// with both line levels, busy, done, the last read byte, the last sampled ack and a
// rejected flag for a command sent while busy. One request is taken per clock while req_stall
// is low; each request goes into the input register, then through one pass of the sequencer
// update into the result register. While a result waits on res_stall the input register
// still takes one more request, and then req_stall rises.
module i2c_master_bit_engine_core
  import i2cm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  req_t                    req,
  output logic                    res_valid,
  input  logic                    res_stall,
  output res_t                    res,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  logic                 in_valid;
  req_t                 in_item;
  logic                 advance;
  logic                 req_fire;
  res_t                 step_res;
  logic [TickWidth-1:0] phase_ticks;

  assign advance   = in_valid && (!res_valid || !res_stall);
  assign req_stall = in_valid && !advance;
  assign req_fire  = req_valid && !req_stall;

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .phase_ticks (phase_ticks)
  );

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_item),
    .phase_ticks (phase_ticks),
    .result      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      in_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done result still shows busy");

  a_reject_not_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |-> !res.done_res)
    else $error("rejected request also completed a command");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> in_valid && res_valid && res_stall)
    else $error("request stalled with no blocked item");

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed request produced no result");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import i2cm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CodeUnused = 3'd7;  // undefined command code, ignored by the block
  localparam logic [2:0] SeqIdle = 3'd7;     // no command sequence in progress
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldoffStart = 150;
  localparam int unsigned HoldoffCycles = 200;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic pready;

  i2c_master_bit_engine_core i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line sequencer shadow state
  logic [2:0] seq_op;
  logic [4:0] seq_phase;
  logic [15:0] seq_ticks;
  logic [7:0] seq_shift;
  logic scl_line;
  logic sda_line;
  logic ack_tx;
  logic ack_rx;
  logic [7:0] read_byte;
  logic [15:0] cfg_phase_ticks;

  req_t pending_requests[$];
  res_t expected_results[$];
  res_t want;

  int unsigned issued_count;
  int unsigned accepted_requests;
  int unsigned results_checked;
  int unsigned done_count;
  int unsigned reject_count;
  int unsigned mismatches;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned holdoff_left;
  int unsigned idle_cycles;
  logic holdoff_done;
  logic req_taken;

  function automatic int unsigned phase_count(logic [2:0] op);
    case (op)
      CMD_STOP: return 2;
      CMD_WRITE, CMD_READ: return 17;
      default: return 3;
    endcase
  endfunction

  function automatic logic [2:0] bit_of_phase(logic [4:0] p);
    logic [4:0] half;
    half = (p - 5'd1) >> 1;
    return 3'd7 - half[2:0];
  endfunction

  // line levels at the start of phase p
  function automatic void enter_phase(logic [2:0] op, logic [4:0] p);
    case (op)
      CMD_START: begin
        if (p == 0) begin
          sda_line = 1'b1;
          scl_line = 1'b1;
        end else if (p == 1) begin
          sda_line = 1'b0;
        end else begin
          scl_line = 1'b0;
        end
      end
      CMD_STOP: begin
        if (p == 0) begin
          sda_line = 1'b0;
          scl_line = 1'b0;
        end else begin
          scl_line = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (p == 0) begin
          scl_line = 1'b0;
        end else if (p[0]) begin
          sda_line = seq_shift[bit_of_phase(p)];
          scl_line = 1'b1;
        end else begin
          scl_line = 1'b0;
        end
      end
      CMD_READ, CMD_RACK: begin
        if (p == 0) begin
          sda_line = 1'b1;
          scl_line = 1'b0;
        end else begin
          scl_line = p[0];
        end
      end
      default: begin
        if (p == 0) begin
          scl_line = 1'b0;
        end else if (p == 1) begin
          sda_line = ack_tx;
          scl_line = 1'b1;
        end else begin
          scl_line = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic int unsigned phase_len();
    return (cfg_phase_ticks == 0) ? 1 : cfg_phase_ticks;
  endfunction

  function automatic res_t step_sequencer(req_t r);
    res_t o;
    logic [2:0] code;
    logic [2:0] op;
    logic busy;
    logic done;
    logic rej;
    code = r.command;
    busy = (seq_op != SeqIdle);
    done = 1'b0;
    rej = 1'b0;
    if (code <= CMD_SACK) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        seq_op = code;
        seq_phase = '0;
        seq_ticks = '0;
        if (code == CMD_WRITE) seq_shift = r.write_data;
        if (code == CMD_READ) seq_shift = '0;
        if (code == CMD_SACK) ack_tx = r.ack_level;
        enter_phase(code, 5'd0);
      end
    end else if (code == CMD_TICK && busy) begin
      seq_ticks = seq_ticks + 16'd1;
      if (seq_ticks >= phase_len()) begin
        op = seq_op;
        seq_ticks = '0;
        // sda is sampled at the end of each scl-high phase
        if (scl_line && seq_phase[0]) begin
          if (op == CMD_READ) seq_shift[bit_of_phase(seq_phase)] = r.sda_level;
          else if (op == CMD_RACK) ack_rx = r.sda_level;
        end
        seq_phase = seq_phase + 5'd1;
        if (seq_phase >= phase_count(op)) begin
          if (op == CMD_STOP) sda_line = 1'b1;
          if (op == CMD_READ) read_byte = seq_shift;
          seq_op = SeqIdle;
          seq_phase = '0;
          done = 1'b1;
        end else begin
          enter_phase(op, seq_phase);
        end
      end
    end
    o.scl_out = scl_line;
    o.sda_out = sda_line;
    o.busy_res = (seq_op != SeqIdle);
    o.done_res = done;
    o.read_data = read_byte;
    o.ack_received = ack_rx;
    o.rejected = rej;
    return o;
  endfunction

  function automatic int unsigned ticks_to_idle();
    if (seq_op == SeqIdle) return 0;
    return (phase_count(seq_op) - seq_phase) * phase_len() - seq_ticks;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_request(logic [2:0] code, logic [7:0] wdata, logic alevel,
                                      logic sda);
    req_t item;
    item.command = cmd_t'(code);
    item.write_data = wdata;
    item.ack_level = alevel;
    item.sda_level = sda;
    pending_requests.push_back(item);
    issued_count++;
  endfunction

  function automatic void add_command(logic [2:0] code);
    add_request(code, rand_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic void add_ticks(int unsigned n);
    repeat (n) add_command(CMD_TICK);
  endfunction

  // mostly complete command sequences, some cut short, some stray requests
  function automatic void add_random_burst();
    logic [2:0] code;
    int unsigned n;
    if ($urandom_range(99) < 82) begin
      code = 3'($urandom_range(5));
      add_command(code);
      n = phase_count(code) * phase_len();
      if ($urandom_range(9) == 0) n = $urandom_range(n);
      repeat (n) begin
        if ($urandom_range(19) == 0) add_command(3'($urandom_range(7)));
        add_command(CMD_TICK);
      end
    end else begin
      add_command(3'($urandom_range(7)));
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_requests != issued_count || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_phase_ticks(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_PHASE_TICKS, 2'b00};
    pwdata <= ApbDataWidth'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    cfg_phase_ticks = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // run any unfinished sequence out so the block is idle
  task automatic settle_idle();
    wait_drained();
    add_ticks(ticks_to_idle());
    wait_drained();
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req <= pending_requests.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result stall, with one long hold-off once traffic is flowing
  always @(negedge clk) begin
    if (holdoff_left != 0) begin
      res_stall <= 1'b1;
      holdoff_left--;
    end else if (!holdoff_done && accepted_requests >= HoldoffStart) begin
      holdoff_done = 1'b1;
      holdoff_left = HoldoffCycles - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.done_res) done_count++;
          if (want.rejected) reject_count++;
          check_field("scl_out", want.scl_out, res.scl_out);
          check_field("sda_out", want.sda_out, res.sda_out);
          check_field("busy_res", want.busy_res, res.busy_res);
          check_field("done_res", want.done_res, res.done_res);
          check_field("read_data", want.read_data, res.read_data);
          check_field("ack_received", want.ack_received, res.ack_received);
          check_field("rejected", want.rejected, res.rejected);
        end
      end
      req_taken = req_valid && !req_stall;
      if (req_taken) begin
        accepted_requests++;
        expected_results.push_back(step_sequencer(req));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned len_list[4];
    int unsigned send_idle_list[4];
    int unsigned recv_stall_list[4];
    int unsigned target;
    len_list = '{0, 2, 3, 1};
    send_idle_list = '{0, 63, 0, 31};
    recv_stall_list = '{0, 0, 63, 31};

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    res_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    seq_op = SeqIdle;
    seq_phase = '0;
    seq_ticks = '0;
    seq_shift = '0;
    scl_line = 1'b1;
    sda_line = 1'b1;
    ack_tx = 1'b0;
    ack_rx = 1'b0;
    read_byte = '0;
    cfg_phase_ticks = PhaseTicksReset;
    issued_count = 0;
    accepted_requests = 0;
    results_checked = 0;
    done_count = 0;
    reject_count = 0;
    mismatches = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    req_taken = 1'b0;
    idle_cycles = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: every command at the reset phase length
    add_request(CMD_TICK, 8'h00, 1'b0, 1'b0);   // tick while idle
    add_request(CodeUnused, 8'hff, 1'b1, 1'b1); // unused code while idle
    add_command(CMD_START);
    add_ticks(1);
    add_command(CMD_STOP);                      // turned away, start still running
    add_request(CodeUnused, 8'h00, 1'b0, 1'b0);
    add_ticks(2);
    add_request(CMD_WRITE, 8'hff, 1'b1, 1'b1);
    add_ticks(17);
    add_request(CMD_READ, 8'h00, 1'b0, 1'b0);
    add_ticks(17);
    add_command(CMD_RACK);
    add_ticks(3);
    add_request(CMD_SACK, 8'h00, 1'b1, 1'b0);
    add_ticks(3);
    add_command(CMD_STOP);
    add_ticks(2);

    for (int p = 0; p < 4; p++) begin
      settle_idle();
      write_phase_ticks(16'(len_list[p]));
      sender_idle_pct = send_idle_list[p];
      receiver_stall_pct = recv_stall_list[p];
      // two halves with a full drain between them
      for (int h = 0; h < 2; h++) begin
        target = issued_count + 138;
        while (issued_count < target) add_random_burst();
        wait_drained();
      end
    end

    // longest phase length: one start that never finishes within the run
    settle_idle();
    write_phase_ticks(16'hffff);
    sender_idle_pct = 31;
    receiver_stall_pct = 31;
    add_command(CMD_START);
    repeat (50) begin
      if ($urandom_range(4) == 0) add_command(3'($urandom_range(7)));
      add_command(CMD_TICK);
    end
    wait_drained();
    repeat (10) @(negedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    $display("checked %0d results from %0d requests at phase lengths 1, 0, 2, 3, 1 and 65535",
             results_checked, accepted_requests);
    $display("%0d command sequences completed, %0d commands turned away while busy",
             done_count, reject_count);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
